// File: rtl/rlde_pkg.sv
// Shared types and constants for the run-length decimal encoder.
// Depends on nothing; the interfaces and the core import it.
`default_nettype none

package rlde_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned BCD_DIGIT_W = 4;
   localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [BCD_DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [BCD_DIGIT_W-1:0] BCD_ADJ_ADD   = 4'd3;

   // Encoder sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BYTE,
      ST_CONVERT,
      ST_DIGIT,
      ST_FOLLOW
   } enc_state_type;

endpackage

`default_nettype wire

// File: rtl/rlde_req_if.sv
// Request channel of the run-length decimal encoder: valid/ready plus payload.
// Depends on rlde_pkg for the byte width.
`default_nettype none

interface rlde_req_if;
   import rlde_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

// File: rtl/rlde_rsp_if.sv
// Response channel of the run-length decimal encoder: valid/ready plus payload.
// Depends on rlde_pkg for the byte width.
`default_nettype none

interface rlde_rsp_if;
   import rlde_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// File: rtl/run_length_decimal_encoder_core.sv
// Run-length encoder core with bit-serial binary to ASCII decimal count output.
// Depends on rlde_pkg, rlde_req_if and rlde_rsp_if.
//
// Usage:
//   req_chan carries one input byte per request, with end_of_stream on the
//   final byte. rsp_chan returns encoded bytes: the run byte, then the run
//   length as ASCII decimal digits (most significant first, no leading zeros)
//   when the length exceeds one. out_last marks the final byte of a stream.
//   A request that extends the open run, or opens the first run, is taken
//   in ST_IDLE without starting a job, so such bytes stream in back to
//   back. A request that closes a run holds req_chan.ready low while the
//   run is sent: the run byte, then, for lengths above one, a bit-serial
//   double-dabble conversion over CW count bits (CW = COUNT_WIDTH capped
//   at 16) and the decimal digits (ND digit slots, leading zeros skipped),
//   plus a trailing single byte when a new byte ends the stream.
//   The result register sits between engine and rsp_chan, so a stalled
//   receiver only stops the engine, and the byte on offer holds until taken.
//   Reset (synchronous, active high) closes any open run and drops output.
`default_nettype none

module run_length_decimal_encoder_core #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rlde_req_if.sink   req_chan,
   rlde_rsp_if.source rsp_chan
);
   import rlde_pkg::*;

   localparam int unsigned CW     = (COUNT_WIDTH > 16) ? 16 : COUNT_WIDTH;
   localparam int unsigned ND     = (CW * 77) / 256 + 1;
   localparam int unsigned BCD_W  = ND * BCD_DIGIT_W;
   localparam int unsigned BITC_W = $clog2(CW + 1);
   localparam int unsigned DIGC_W = $clog2(ND + 1);
   localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   // Run state
   logic              run_open_ff, run_open_in;
   logic [BYTE_W-1:0] run_byte_ff, run_byte_in;
   logic [CW-1:0]     run_len_ff, run_len_in;

   // Emission job
   enc_state_type     state_ff, state_in;
   logic [BYTE_W-1:0] job_byte_ff, job_byte_in;
   logic [CW-1:0]     job_len_ff, job_len_in;
   logic              job_last_ff, job_last_in;
   logic              follow_ff, follow_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic [BITC_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIGC_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic              started_ff, started_in;

   // Result register
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic                   accept;
   logic                   same;
   logic                   slot_free;
   logic                   out_load;
   logic [CW-1:0]          len_sat;
   logic [BCD_W-1:0]       bcd_adj;
   logic [BCD_DIGIT_W-1:0] top_digit;

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign accept            = req_chan.valid && req_chan.ready;
   assign same              = run_open_ff && (req_chan.in_byte == run_byte_ff);
   assign len_sat           = (run_len_ff == CNT_MAX) ? run_len_ff : run_len_ff + CNT_ONE;
   assign slot_free         = !out_valid_ff || rsp_chan.ready;
   assign top_digit         = bcd_ff[BCD_W-1 -: BCD_DIGIT_W];

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.out_last = out_last_ff;

   // Add three to every BCD digit of five or more before the next shift
   always_comb begin
      for (int i = 0; i < ND; i++) begin
         if (bcd_ff[i*BCD_DIGIT_W +: BCD_DIGIT_W] >= BCD_ADJ_LIMIT) begin
            bcd_adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] =
               bcd_ff[i*BCD_DIGIT_W +: BCD_DIGIT_W] + BCD_ADJ_ADD;
         end else begin
            bcd_adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] = bcd_ff[i*BCD_DIGIT_W +: BCD_DIGIT_W];
         end
      end
   end

   // Next state and outputs of the sequencer
   always_comb begin
      state_in    = state_ff;
      run_open_in = run_open_ff;
      run_byte_in = run_byte_ff;
      run_len_in  = run_len_ff;
      job_byte_in = job_byte_ff;
      job_len_in  = job_len_ff;
      job_last_in = job_last_ff;
      follow_in   = follow_ff;
      bcd_in      = bcd_ff;
      bit_cnt_in  = bit_cnt_ff;
      dig_cnt_in  = dig_cnt_ff;
      started_in  = started_ff;
      out_load    = 1'b0;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (same) begin
                  if (req_chan.end_of_stream) begin
                     // Close the run with this byte and send it as last
                     job_byte_in = run_byte_ff;
                     job_len_in  = len_sat;
                     job_last_in = 1'b1;
                     follow_in   = 1'b0;
                     run_open_in = 1'b0;
                     run_len_in  = '0;
                     state_in    = ST_BYTE;
                  end else begin
                     run_len_in = len_sat;
                  end
               end else if (run_open_ff) begin
                  // Send the old run; a stream end adds the new byte alone
                  job_byte_in = run_byte_ff;
                  job_len_in  = run_len_ff;
                  job_last_in = 1'b0;
                  follow_in   = req_chan.end_of_stream;
                  run_byte_in = req_chan.in_byte;
                  run_len_in  = req_chan.end_of_stream ? '0 : CNT_ONE;
                  run_open_in = !req_chan.end_of_stream;
                  state_in    = ST_BYTE;
               end else begin
                  if (req_chan.end_of_stream) begin
                     job_byte_in = req_chan.in_byte;
                     job_len_in  = CNT_ONE;
                     job_last_in = 1'b1;
                     follow_in   = 1'b0;
                     run_len_in  = '0;
                     state_in    = ST_BYTE;
                  end else begin
                     run_byte_in = req_chan.in_byte;
                     run_len_in  = CNT_ONE;
                     run_open_in = 1'b1;
                  end
               end
            end
         end

         ST_BYTE: begin
            if (slot_free) begin
               out_load    = 1'b1;
               out_byte_in = job_byte_ff;
               out_last_in = job_last_ff && (job_len_ff == CNT_ONE);
               if (job_len_ff != CNT_ONE) begin
                  bcd_in     = '0;
                  bit_cnt_in = BITC_W'(CW);
                  state_in   = ST_CONVERT;
               end else if (follow_ff) begin
                  state_in = ST_FOLLOW;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_CONVERT: begin
            // Shift one count bit into the BCD register per cycle
            bcd_in     = {bcd_adj[BCD_W-2:0], job_len_ff[CW-1]};
            job_len_in = {job_len_ff[CW-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == BITC_W'(1)) begin
               dig_cnt_in = DIGC_W'(ND);
               started_in = 1'b0;
               state_in   = ST_DIGIT;
            end
         end

         ST_DIGIT: begin
            if (!started_ff && (top_digit == '0)) begin
               // Drop a leading zero
               bcd_in     = {bcd_ff[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else if (slot_free) begin
               out_load    = 1'b1;
               out_byte_in = ASCII_ZERO + BYTE_W'(top_digit);
               out_last_in = job_last_ff && (dig_cnt_ff == DIGC_W'(1));
               started_in  = 1'b1;
               bcd_in      = {bcd_ff[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
               dig_cnt_in  = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == DIGC_W'(1)) begin
                  state_in = follow_ff ? ST_FOLLOW : ST_IDLE;
               end
            end
         end

         ST_FOLLOW: begin
            if (slot_free) begin
               out_load    = 1'b1;
               out_byte_in = run_byte_ff;
               out_last_in = 1'b1;
               follow_in   = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_load || (out_valid_ff && !rsp_chan.ready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_open_ff  <= 1'b0;
         run_len_ff   <= '0;
         follow_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_open_ff  <= run_open_in;
         run_len_ff   <= run_len_in;
         follow_ff    <= follow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      run_byte_ff <= run_byte_in;
      job_byte_ff <= job_byte_in;
      job_len_ff  <= job_len_in;
      job_last_ff <= job_last_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      started_ff  <= started_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

`ifndef NO_ASSERTIONS
   a_open_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      run_open_ff |-> (run_len_ff != '0))
      else $error("open run with zero length");

   a_eos_closes_run: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_stream) |=> !run_open_ff)
      else $error("run still open after end of stream");

   a_digit_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT) |-> (dig_cnt_ff != '0))
      else $error("digit phase with no digits left");

   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_last_in) |=> (state_ff == ST_IDLE))
      else $error("engine busy after last byte of stream");

   a_lead_digit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (out_load && (state_ff == ST_DIGIT) && !started_ff) |-> (top_digit != '0))
      else $error("leading zero sent");
`endif

endmodule

`default_nettype wire
